// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the glyph writer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");
`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

// ===== rtl/tcgw_pkg.sv =====
// Types and constants of the text console glyph writer
`timescale 1ns / 1ps
`default_nettype none
package tcgw_pkg;

   localparam int GLYPH_COUNT    = 128;
   localparam int MAX_SCREEN_DIM = 4096;
   localparam int CELL           = 8;
   localparam int CELL_AW        = $clog2(CELL);
   localparam int GLYPH_AW       = $clog2(GLYPH_COUNT);
   localparam int STORE_AW       = GLYPH_AW + CELL_AW;
   localparam int STORE_DEPTH    = GLYPH_COUNT * CELL;
   localparam int STEP_W         = 2 * CELL_AW;

   localparam int CODE_W   = 8;
   localparam int SLOT_W   = 10;
   localparam int DIM_W    = 13;
   localparam int PITCH_W  = 15;
   localparam int COL_W    = 12;
   localparam int ROW_W    = 13;
   localparam int OFF_W    = 26;
   localparam int DATA_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CHAR_RETURN    = 8'd13;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WORD     = 2'd3;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [PITCH_W-1:0] PITCH_RESET  = 15'd2560;

   localparam logic [DATA_W-1:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [DATA_W-1:0] COLOR_BLACK = 24'h000000;
   localparam logic [DATA_W-1:0] HALF_MASK   = 24'h00FFFF;

   typedef enum logic [2:0] {
      KIND_FONT,
      KIND_GLYPH,
      KIND_HIGH,
      KIND_BACKSPACE,
      KIND_NEWLINE,
      KIND_RETURN
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   code;
      logic [SLOT_W-1:0]   slot;
      logic [CODE_W-1:0]   bits;
   } qentry_type;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [PITCH_W-1:0] pitch;
      logic               half;
      logic               clear_ok;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/tcgw_ram.sv =====
// Generic single-port-write RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module tcgw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/tcgw_front.sv =====
// Request intake: classifies requests and queues them for the draw engine
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcgw_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [tcgw_pkg::CODE_W-1:0]    req_char_code,
   input  wire logic [tcgw_pkg::SLOT_W-1:0]    req_font_slot,
   input  wire logic [tcgw_pkg::CODE_W-1:0]    req_font_bits,
   output tcgw_pkg::qentry_type                head,
   output logic                                head_valid,
   input  wire logic                           pop
);
   import tcgw_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   qentry_type              entries_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   qentry_type              entry;
   logic                    push;

   always_comb begin
      entry.code = req_char_code;
      entry.slot = req_font_slot;
      entry.bits = req_font_bits;
      if (!req_cmd) begin
         entry.kind = KIND_FONT;
      end else begin
         unique case (req_char_code)
            CHAR_BACKSPACE: entry.kind = KIND_BACKSPACE;
            CHAR_NEWLINE:   entry.kind = KIND_NEWLINE;
            CHAR_RETURN:    entry.kind = KIND_RETURN;
            default:        entry.kind = req_char_code[CODE_W-1] ? KIND_HIGH : KIND_GLYPH;
         endcase
      end
   end

   assign req_ready  = (count_ff != QCNT_W'(QDEPTH));
   assign push       = req_valid && req_ready;
   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && count_ff == '0)
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH))
endmodule
`default_nettype wire

// ===== rtl/tcgw_back.sv =====
// Draw engine: cursor, font store, pixel walk and response register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcgw_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tcgw_pkg::cfg_type              cfg,
   input  wire tcgw_pkg::qentry_type           head,
   input  wire logic                           head_valid,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_pixel_valid,
   output logic      [tcgw_pkg::OFF_W-1:0]     rsp_byte_offset,
   output logic      [tcgw_pkg::DATA_W-1:0]    rsp_pixel_data,
   output logic                                rsp_clear_after,
   output logic                                rsp_last_of_run
);
   import tcgw_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_START  = 6'b000010,
      ST_BASE   = 6'b000100,
      ST_FETCH  = 6'b001000,
      ST_DRAW   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [OFF_W-1:0]        base_ff, base_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [OFF_W-1:0]        pend_off_ff, pend_off_in;
   logic [DATA_W-1:0]       pend_data_ff, pend_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pix_ff, rsp_pix_in;
   logic [OFF_W-1:0]        rsp_off_ff, rsp_off_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_clear_ff, rsp_clear_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [STORE_AW-1:0]     ram_rd_addr;
   logic [CODE_W-1:0]       ram_rd_data;

   logic [CELL_AW-1:0]      row_idx, col_idx;
   logic [CODE_W-1:0]       row_bits, bits_sh;
   logic [DIM_W-1:0]        pix_x;
   logic [ROW_W:0]          pix_y;
   logic                    hit, stall, out_free, is_bs;
   logic [OFF_W-1:0]        pix_off, x_off;
   logic [DATA_W-1:0]       pix_data;
   logic [ROW_W+PITCH_W-1:0] base_prod;
   logic [COL_W-1:0]        col_a, col_b;
   logic [ROW_W-1:0]        row_a, row_b;
   logic                    clear_flag;

   tcgw_ram #(.WIDTH(CODE_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (STORE_AW'(head.slot)),
      .wr_data (head.bits),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign is_bs       = (head.kind == KIND_BACKSPACE);
   assign row_idx     = step_ff[STEP_W-1:CELL_AW];
   assign col_idx     = step_ff[CELL_AW-1:0];
   assign ram_wr_en   = (state_ff == ST_IDLE) && head_valid && (head.kind == KIND_FONT);
   assign ram_rd_en   = (state_ff == ST_FETCH);
   assign ram_rd_addr = {head.code[GLYPH_AW-1:0], row_idx};
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // pixel under the walk position
   always_comb begin
      row_bits = is_bs ? '1 : ram_rd_data;
      bits_sh  = CODE_W'(row_bits << col_idx);
      pix_x    = DIM_W'(col_ff) + DIM_W'(col_idx);
      pix_y    = (ROW_W+1)'(row_ff) + (ROW_W+1)'(row_idx);
      hit      = bits_sh[CODE_W-1] && (pix_x < cfg.width) && (pix_y < (ROW_W+1)'(cfg.height));
      x_off    = cfg.half ? OFF_W'({pix_x, 1'b0}) : OFF_W'({pix_x, 2'b00});
      pix_off  = base_ff + x_off;
      pix_data = is_bs ? COLOR_BLACK : (cfg.half ? (COLOR_WHITE & HALF_MASK) : COLOR_WHITE);
      stall    = hit && pend_valid_ff && !out_free;
      base_prod = (ROW_W+PITCH_W)'(row_ff) * (ROW_W+PITCH_W)'(cfg.pitch);
   end

   // cursor after a non-backspace character
   always_comb begin
      col_a = col_ff;
      row_a = row_ff;
      case (head.kind)
         KIND_NEWLINE: begin
            col_a = '0;
            row_a = row_ff + ROW_W'(CELL);
         end
         KIND_RETURN: begin
            col_a = '0;
         end
         default: begin
            col_a = col_ff + COL_W'(CELL);
         end
      endcase
      col_b = col_a;
      row_b = row_a;
      if ((DIM_W'(col_a) + DIM_W'(CELL)) > cfg.width) begin
         col_b = '0;
         row_b = row_a + ROW_W'(CELL);
      end
      clear_flag = ((ROW_W+1)'(row_b) + (ROW_W+1)'(CELL)) > (ROW_W+1)'(cfg.height)
                   && cfg.clear_ok;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      pend_valid_in = pend_valid_ff;
      pend_off_in   = pend_off_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_clear_in  = rsp_clear_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  KIND_FONT:      pop = 1'b1;
                  KIND_BACKSPACE: state_in = ST_START;
                  KIND_GLYPH:     state_in = ST_BASE;
                  default:        state_in = ST_FINISH;
               endcase
            end
         end
         ST_START: begin
            if (col_ff >= COL_W'(CELL)) begin
               col_in = col_ff - COL_W'(CELL);
            end else if (row_ff >= ROW_W'(CELL)) begin
               row_in = row_ff - ROW_W'(CELL);
               col_in = (cfg.width >= DIM_W'(CELL)) ? COL_W'(cfg.width - DIM_W'(CELL)) : '0;
            end
            state_in = ST_BASE;
         end
         ST_BASE: begin
            base_in  = base_prod[OFF_W-1:0];
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (!stall) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_pix_in   = 1'b1;
                     rsp_off_in   = pend_off_ff;
                     rsp_data_in  = pend_data_ff;
                     rsp_clear_in = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_off_in   = pix_off;
                  pend_data_in  = pix_data;
               end
               step_in = step_ff + 1'b1;
               if (col_idx == '1) begin
                  if (row_idx == '1) begin
                     state_in = ST_FINISH;
                  end else begin
                     base_in  = base_ff + OFF_W'(cfg.pitch);
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pix_in    = pend_valid_ff;
               rsp_off_in    = pend_valid_ff ? pend_off_ff : '0;
               rsp_data_in   = pend_valid_ff ? pend_data_ff : '0;
               rsp_clear_in  = !is_bs && clear_flag;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               step_in       = '0;
               pop           = 1'b1;
               state_in      = ST_IDLE;
               if (!is_bs) begin
                  col_in = clear_flag ? '0 : col_b;
                  row_in = clear_flag ? '0 : row_b;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pend_off_ff  <= pend_off_in;
      pend_data_ff <= pend_data_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_clear_ff <= rsp_clear_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_valid = rsp_pix_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_pixel_data  = rsp_data_ff;
   assign rsp_clear_after = rsp_clear_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `ASSERT_NEVER(a_pend_in_idle, clock, reset, pend_valid_ff && state_ff == ST_IDLE)
   `ASSERT_ALWAYS(a_idle_step_zero, clock, reset, state_ff == ST_IDLE |-> step_ff == '0)
endmodule
`default_nettype wire

// ===== rtl/text_console_glyph_writer.sv =====
// Top level of the 8x8 text console glyph writer
//
//   channel   ports    handshake            carries
//   request   req_*    req_valid/req_ready  font row load or character
//   response  rsp_*    rsp_valid/rsp_ready  pixel write, last/clear marks
//   config    csr_*    csr_write_enable     screen size, pitch, pixel size
//
// Font load: the row passes the queue, then the engine writes it to the font store.
// Newline, return, codes 128 and up: no pixel walk, straight to the finish state.
// Glyph: 8 rows of one font store read plus 8 pixels, one pixel position a cycle
// while the response does not stall, plus setup and finish; backspace adds a cursor step.
// Synchronous active-high reset; no clearing pass, the font store is not reset.
// A two-entry request queue lets intake continue while the engine draws.
`timescale 1ns / 1ps
`default_nettype none
module text_console_glyph_writer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_cmd,
   input  wire logic [tcgw_pkg::CODE_W-1:0]      req_char_code,
   input  wire logic [tcgw_pkg::SLOT_W-1:0]      req_font_slot,
   input  wire logic [tcgw_pkg::CODE_W-1:0]      req_font_bits,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_pixel_valid,
   output logic      [tcgw_pkg::OFF_W-1:0]       rsp_byte_offset,
   output logic      [tcgw_pkg::DATA_W-1:0]      rsp_pixel_data,
   output logic                                  rsp_clear_after,
   output logic                                  rsp_last_of_run,
   input  wire logic                             csr_write_enable,
   input  wire logic [tcgw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tcgw_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tcgw_pkg::*;

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic               half_ff, half_in;
   cfg_type            cfg;
   qentry_type         head;
   logic               head_valid;
   logic               pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      half_in   = half_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_write_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: height_in = csr_write_data[DIM_W-1:0];
            CSR_LINE_PITCH:    pitch_in  = csr_write_data[PITCH_W-1:0];
            CSR_HALF_WORD:     half_in   = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         pitch_ff  <= PITCH_RESET;
         half_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pitch_ff  <= pitch_in;
         half_ff   <= half_in;
      end
   end

   // sizes above the maximum saturate
   always_comb begin
      cfg.width    = (width_ff > DIM_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM) : width_ff;
      cfg.height   = (height_ff > DIM_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM) : height_ff;
      cfg.pitch    = pitch_ff;
      cfg.half     = half_ff;
      cfg.clear_ok = (width_ff != '0) && (height_ff != '0) && (pitch_ff != '0);
   end

   tcgw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_font_slot (req_font_slot),
      .req_font_bits (req_font_bits),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop)
   );

   tcgw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_pixel_data  (rsp_pixel_data),
      .rsp_clear_after (rsp_clear_after),
      .rsp_last_of_run (rsp_last_of_run)
   );
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the text console glyph writer: pixel write predictor plus drivers
`timescale 1ns / 1ps
module tb_top;
   import tcgw_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 200000;

   typedef struct packed {
      logic              pixel_valid;
      logic [OFF_W-1:0]  byte_offset;
      logic [DATA_W-1:0] pixel_data;
      logic              clear_after;
      logic              last_of_run;
   } pixel_write_type;

   class pixel_write_predictor;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [PITCH_W-1:0] pitch;
      logic               half;
      int unsigned        col;
      int unsigned        row;
      logic [CODE_W-1:0]  glyph_rows [STORE_DEPTH];
      bit                 row_written [STORE_DEPTH];
      pixel_write_type    fresh [$];
      pixel_write_type    expected_writes [$];
      int                 mismatch_count;

      function new();
         width = WIDTH_RESET;
         height = HEIGHT_RESET;
         pitch = PITCH_RESET;
         half = 1'b0;
         col = 0;
         row = 0;
         mismatch_count = 0;
         foreach (row_written[i]) row_written[i] = 1'b0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SCREEN_WIDTH:  width = data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: height = data[DIM_W-1:0];
            CSR_LINE_PITCH:    pitch = data[PITCH_W-1:0];
            CSR_HALF_WORD:     half = data[0];
            default: ;
         endcase
      endfunction

      function bit glyph_loaded(int code);
         for (int r = 0; r < CELL; r++)
            if (!row_written[code * CELL + r]) return 1'b0;
         return 1'b1;
      endfunction

      function int unsigned clamp_dim(logic [DIM_W-1:0] v);
         return (v > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : v;
      endfunction

      function void add_pixel(int unsigned x, int unsigned y, logic [DATA_W-1:0] color);
         pixel_write_type p;
         logic [63:0]     off;
         if (x >= clamp_dim(width) || y >= clamp_dim(height) || fresh.size() >= 64) return;
         off = 64'(y) * 64'(pitch) + 64'(x) * (half ? 64'd2 : 64'd4);
         p.pixel_valid = 1'b1;
         p.byte_offset = off[OFF_W-1:0];
         p.pixel_data = half ? (color & HALF_MASK) : color;
         p.clear_after = 1'b0;
         p.last_of_run = 1'b0;
         fresh.push_back(p);
      endfunction

      function void note_request(bit cmd, logic [CODE_W-1:0] code, logic [SLOT_W-1:0] slot,
                                 logic [CODE_W-1:0] bits);
         int unsigned     w;
         int unsigned     h;
         bit              clear;
         pixel_write_type p;
         if (!cmd) begin
            glyph_rows[slot] = bits;
            row_written[slot] = 1'b1;
            return;
         end
         w = clamp_dim(width);
         h = clamp_dim(height);
         clear = 1'b0;
         fresh.delete();
         if (code == CHAR_BACKSPACE) begin
            if (col >= CELL) begin
               col -= CELL;
            end else if (row >= CELL) begin
               row -= CELL;
               col = (w >= CELL) ? ((w - CELL) & ((1 << COL_W) - 1)) : 0;
            end
            for (int r = 0; r < CELL; r++)
               for (int c = 0; c < CELL; c++)
                  add_pixel(col + c, row + r, COLOR_BLACK);
         end else begin
            if (code == CHAR_NEWLINE) begin
               col = 0;
               row = (row + CELL) & ((1 << ROW_W) - 1);
            end else if (code == CHAR_RETURN) begin
               col = 0;
            end else begin
               if (code < GLYPH_COUNT)
                  for (int r = 0; r < CELL; r++)
                     for (int c = 0; c < CELL; c++)
                        if (glyph_rows[code * CELL + r][CELL - 1 - c])
                           add_pixel(col + c, row + r, COLOR_WHITE);
               col = (col + CELL) & ((1 << COL_W) - 1);
            end
            if (col + CELL > w) begin
               col = 0;
               row = (row + CELL) & ((1 << ROW_W) - 1);
            end
            if (row + CELL > h && width != 0 && height != 0 && pitch != 0) begin
               clear = 1'b1;
               col = 0;
               row = 0;
            end
         end
         if (fresh.size() == 0) begin
            p = '0;
            fresh.push_back(p);
         end
         fresh[fresh.size() - 1].clear_after = clear;
         fresh[fresh.size() - 1].last_of_run = 1'b1;
         foreach (fresh[i]) expected_writes.push_back(fresh[i]);
      endfunction

      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_pixel(pixel_write_type got);
         pixel_write_type want;
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write, offset %h", got.byte_offset));
            return;
         end
         want = expected_writes.pop_front();
         if (got.pixel_valid !== want.pixel_valid)
            report_mismatch($sformatf("pixel_valid %b, want %b", got.pixel_valid,
                                      want.pixel_valid));
         if (got.byte_offset !== want.byte_offset)
            report_mismatch($sformatf("byte_offset %h, want %h", got.byte_offset,
                                      want.byte_offset));
         if (got.pixel_data !== want.pixel_data)
            report_mismatch($sformatf("pixel_data %h, want %h", got.pixel_data,
                                      want.pixel_data));
         if (got.clear_after !== want.clear_after)
            report_mismatch($sformatf("clear_after %b, want %b", got.clear_after,
                                      want.clear_after));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b", got.last_of_run,
                                      want.last_of_run));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [CODE_W-1:0]     req_char_code;
   logic [SLOT_W-1:0]     req_font_slot;
   logic [CODE_W-1:0]     req_font_bits;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_pixel_valid;
   logic [OFF_W-1:0]      rsp_byte_offset;
   logic [DATA_W-1:0]     rsp_pixel_data;
   logic                  rsp_clear_after;
   logic                  rsp_last_of_run;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pixel_write_predictor  predictor;
   bit                    calm = 1'b0;
   int                    hold_asks = 0;
   int                    hold_taken = 0;

   text_console_glyph_writer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_char_code    (req_char_code),
      .req_font_slot    (req_font_slot),
      .req_font_bits    (req_font_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_pixel_data   (rsp_pixel_data),
      .rsp_clear_after  (rsp_clear_after),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         predictor.check_pixel(pixel_write_type'({rsp_pixel_valid, rsp_byte_offset,
                                                  rsp_pixel_data, rsp_clear_after,
                                                  rsp_last_of_run}));
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < 30) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic idle_gap();
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < 30) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_request(bit cmd, logic [CODE_W-1:0] code, logic [SLOT_W-1:0] slot,
                               logic [CODE_W-1:0] bits);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_char_code <= code;
      req_font_slot <= slot;
      req_font_bits <= bits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predictor.note_request(cmd, code, slot, bits);
      idle_gap();
   endtask

   task automatic send_char(logic [CODE_W-1:0] code);
      send_request(1'b1, code, SLOT_W'($urandom), CODE_W'($urandom));
   endtask

   task automatic send_font(logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] bits);
      send_request(1'b0, CODE_W'($urandom), slot, bits);
   endtask

   // style 0: solid, 1: empty, otherwise random rows
   task automatic load_glyph(int code, int style);
      logic [CODE_W-1:0] bits;
      for (int r = 0; r < CELL; r++) begin
         bits = (style == 0) ? 8'hFF : (style == 1) ? 8'h00 : CODE_W'($urandom);
         send_font(SLOT_W'(code * CELL + r), bits);
      end
   endtask

   // glyphs come from a small pool so font loads stay few
   task automatic random_item();
      int                pick;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_font(SLOT_W'($urandom), CODE_W'($urandom));
      end else if (pick < 24) begin
         case ($urandom_range(3))
            0, 1:    send_char(CHAR_BACKSPACE);
            2:       send_char(CHAR_NEWLINE);
            default: send_char(CHAR_RETURN);
         endcase
      end else if (pick < 32) begin
         send_char(CODE_W'($urandom_range(255, GLYPH_COUNT)));
      end else begin
         code = ($urandom_range(4) == 0) ? 8'd32 : CODE_W'(64 + $urandom_range(3));
         if (!predictor.glyph_loaded(code) || $urandom_range(19) == 0)
            load_glyph(code, $urandom_range(3));
         send_char(code);
      end
   endtask

   task automatic run_random(int count, int calm_from, int calm_to);
      for (int i = 0; i < count; i++) begin
         calm = (i >= calm_from && i < calm_to);
         random_item();
      end
      calm = 1'b0;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (predictor.expected_writes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      predictor.set_reg(idx, data);
   endtask

   task automatic program_screen(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                                 logic [CSR_DATA_W-1:0] p, bit half);
      wait_idle();
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
      write_reg(CSR_LINE_PITCH, p);
      write_reg(CSR_HALF_WORD, CSR_DATA_W'(half));
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CODE_W-1:0] a_rows [CELL];
      predictor = new();
      a_rows = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h18, 8'h81};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= 1'b0;
      req_char_code <= '0;
      req_font_slot <= '0;
      req_font_bits <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset geometry 640x480
      for (int r = 0; r < CELL; r++) send_font(SLOT_W'(65 * CELL + r), a_rows[r]);
      send_char(8'd65);
      send_char(8'd200);
      send_char(CHAR_BACKSPACE);
      send_char(CHAR_RETURN);
      send_char(CHAR_BACKSPACE);      // top left: cursor stays
      send_char(CHAR_NEWLINE);
      send_char(CHAR_BACKSPACE);      // up one line to the right edge
      send_char(8'd65);               // last column, then wrap
      load_glyph(32, 1);
      send_char(8'd32);               // empty glyph

      // small odd screen: clears, partial clipping; long response hold-off
      program_screen(61, 44, 256, 1'b1);
      hold_asks++;
      repeat (6) send_char(8'd65);
      run_random(30, 8, 22);

      // narrow screen
      program_screen(5, 40, 20, 1'b0);
      run_random(10, 0, 0);

      // oversized dims saturate
      program_screen(8191, 8191, 32767, 1'b0);
      repeat (4) send_char(CHAR_NEWLINE);
      run_random(6, 0, 0);

      // zero pitch: no clear, the cursor runs past the bottom
      program_screen(64, 16, 0, 1'b1);
      repeat (4) send_char(CHAR_NEWLINE);
      run_random(6, 0, 0);

      program_screen(0, 0, 1, 1'b0);
      run_random(6, 0, 0);

      program_screen(8, 8, 1, 1'b1);
      run_random(6, 0, 0);

      program_screen(4096, 16, 16384, 1'b0);
      run_random(8, 2, 6);

      wait_idle();
      if (predictor.expected_writes.size() != 0)
         predictor.report_mismatch($sformatf("%0d writes never arrived",
                                             predictor.expected_writes.size()));
      if (predictor.mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tcgw_pkg.sv
rtl/tcgw_ram.sv
rtl/tcgw_front.sv
rtl/tcgw_back.sv
rtl/text_console_glyph_writer.sv
verif/tb_top.sv
